### design/mi3_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the 3x3 matrix inverse core
// no dependencies
package mi3_pkg;

	localparam int ELEM_W_DEF = 16;
	localparam int FRAC_DEF   = 8;

	// determinant bound registers, Q24.24 magnitudes
	localparam int CFG_W      = 48;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 4;

	localparam logic [CFG_W-1:0] DET_MIN_RST = 48'd1;
	localparam logic [CFG_W-1:0] DET_MAX_RST = 48'd211106232532992;

	// register select, taken from paddr[3]
	localparam logic REG_DET_MIN = 1'b0;
	localparam logic REG_DET_MAX = 1'b1;

	localparam int NUM_ELEM = 9;

	typedef struct packed {
		logic valid;
		logic reject;
	} mi3_ctl_t;

endpackage

### design/mi3_adj.sv
`timescale 1ns / 1ps
// cofactor and determinant pipeline, four stages, with bound check
// depends on mi3_pkg
module mi3_adj import mi3_pkg::*; #(
	parameter int W = ELEM_W_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [W-1:0]     m [NUM_ELEM],
	input  logic [CFG_W-1:0]        det_min,
	input  logic [CFG_W-1:0]        det_max,
	output logic [2*W:0]            cof_mag [NUM_ELEM],
	output logic                    cof_neg [NUM_ELEM],
	output logic [4*W+2:0]          dmag,
	output logic                    dneg,
	output mi3_ctl_t                ctl
);

	localparam int CW   = 2 * W + 1;
	localparam int PW   = W + CW;
	localparam int DW   = PW + 2;
	localparam int CMPW = (DW > CFG_W) ? DW : CFG_W;
	localparam int OW   = 4 * W + 3;

	// cofactor k = m[PA_X]*m[PA_Y] - m[PB_X]*m[PB_Y], sign of the adjugate folded in
	localparam int PA_X [NUM_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int PA_Y [NUM_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int PB_X [NUM_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int PB_Y [NUM_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	logic signed [2*W-1:0] pa_s1 [NUM_ELEM];
	logic signed [2*W-1:0] pb_s1 [NUM_ELEM];
	logic signed [W-1:0]   a0_s1 [3];
	logic signed [W-1:0]   a0_s2 [3];
	logic signed [CW-1:0]  cof_s2 [NUM_ELEM];
	logic signed [CW-1:0]  cof_s3 [NUM_ELEM];
	logic signed [PW-1:0]  dp_s3 [3];
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic                  rej_s4;

	logic signed [DW-1:0]  det;
	logic [DW-1:0]         det_mag;
	logic                  det_rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_ELEM; k++) begin
			pa_s1[k]  <= m[PA_X[k]] * m[PA_Y[k]];
			pb_s1[k]  <= m[PB_X[k]] * m[PB_Y[k]];
			cof_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
			cof_s3[k] <= cof_s2[k];
		end
		for (int j = 0; j < 3; j++) begin
			a0_s1[j] <= m[j];
			a0_s2[j] <= a0_s1[j];
			dp_s3[j] <= a0_s2[j] * cof_s2[3 * j];
		end
	end

	// expansion along row 0
	always_comb begin
		det     = DW'(dp_s3[0]) + DW'(dp_s3[1]) + DW'(dp_s3[2]);
		det_mag = det[DW-1] ? DW'(-det) : DW'(det);
		det_rej = (det_mag == '0) || (CMPW'(det_mag) < CMPW'(det_min))
			|| (CMPW'(det_mag) > CMPW'(det_max));
	end

	always_ff @(posedge clk) begin
		dmag   <= OW'(det_mag);
		dneg   <= det[DW-1];
		rej_s4 <= det_rej;
		for (int k = 0; k < NUM_ELEM; k++) begin
			cof_neg[k] <= cof_s3[k][CW-1];
			cof_mag[k] <= cof_s3[k][CW-1] ? CW'(-cof_s3[k]) : CW'(cof_s3[k]);
		end
	end

	assign ctl.valid  = v_s4;
	assign ctl.reject = rej_s4;

endmodule

### design/mi3_div_lane.sv
`timescale 1ns / 1ps
// one divider lane: rounded |cof| * 2^(2F) / |det|, one quotient bit per stage
// depends on mi3_pkg
module mi3_div_lane import mi3_pkg::*; #(
	parameter int W = ELEM_W_DEF,
	parameter int F = FRAC_DEF
) (
	input  logic              clk,
	input  logic [2*W:0]      cmag,
	input  logic              cneg,
	input  logic [4*W+2:0]    dmag,
	input  logic              dneg,
	output logic [W:0]        q,
	output logic              neg
);

	localparam int CW  = 2 * W + 1;
	localparam int DW  = 4 * W + 3;
	localparam int NW0 = (CW + 2 * F > DW) ? CW + 2 * F : DW;
	localparam int NW  = NW0 + 1;
	localparam int XW  = (NW > DW + W + 1) ? NW : DW + W + 1;

	logic [XW-1:0] rem_s [W+2];
	logic [DW-1:0] den_s [W+2];
	logic [W:0]    q_s   [W+2];
	logic          neg_s [W+2];

	// numerator with half the divisor added for round to nearest
	always_ff @(posedge clk) begin
		rem_s[0] <= (XW'(cmag) << (2 * F)) + XW'(dmag >> 1);
		den_s[0] <= dmag;
		q_s[0]   <= '0;
		neg_s[0] <= cneg ^ dneg;
	end

	// top quotient bit flags an overflow past the element range
	for (genvar s = 0; s <= W; s++) begin : g_step
		localparam int B = W - s;
		logic [XW-1:0] sh;
		logic          ge;

		assign sh = XW'(den_s[s]) << B;
		assign ge = rem_s[s] >= sh;

		always_ff @(posedge clk) begin
			rem_s[s+1] <= ge ? rem_s[s] - sh : rem_s[s];
			den_s[s+1] <= den_s[s];
			q_s[s+1]   <= {q_s[s][W-1:0], ge};
			neg_s[s+1] <= neg_s[s];
		end
	end

	assign q   = q_s[W+1];
	assign neg = neg_s[W+1];

endmodule

### design/mi3_merge.sv
`timescale 1ns / 1ps
// merge of the nine lanes: saturation, sign, status and output register
// depends on mi3_pkg
module mi3_merge import mi3_pkg::*; #(
	parameter int W = ELEM_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [W:0]         q [NUM_ELEM],
	input  logic               neg [NUM_ELEM],
	input  mi3_ctl_t           ctl,
	output logic               done,
	output logic signed [W-1:0] inv [NUM_ELEM],
	output logic               status,
	output logic               saturated
);

	localparam logic [W:0] HALF = (W + 1)'(1) << (W - 1);

	logic [W:0]   lim [NUM_ELEM];
	logic [W:0]   qc  [NUM_ELEM];
	logic         sat [NUM_ELEM];
	logic [W-1:0] val [NUM_ELEM];
	logic         any_sat;

	always_comb begin
		any_sat = 1'b0;
		for (int k = 0; k < NUM_ELEM; k++) begin
			lim[k]  = neg[k] ? HALF : HALF - (W + 1)'(1);
			sat[k]  = q[k] > lim[k];
			qc[k]   = sat[k] ? lim[k] : q[k];
			val[k]  = neg[k] ? W'(-qc[k]) : W'(qc[k]);
			any_sat = any_sat | sat[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		status    <= ctl.reject;
		saturated <= !ctl.reject && any_sat;
		for (int k = 0; k < NUM_ELEM; k++) begin
			inv[k] <= ctl.reject ? '0 : val[k];
		end
	end

endmodule

### design/matrix3x3_inverse_core.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate, Q8.8 in and out; one matrix per cycle, busy stays low
// four cofactor/determinant stages, one numerator stage,
// ELEMENT_WIDTH + 1 divider stages per lane, one output register
// nine divider lanes run side by side, one quotient bit per stage each
// arst_n clears the pipeline valids and loads the bound registers; results cannot be stalled
module matrix3x3_inverse_core import mi3_pkg::*; #(
	parameter int ELEMENT_WIDTH = ELEM_W_DEF,
	parameter int FRACTION_BITS = FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item transfer
	input  logic                          start,
	output logic                          busy,
	input  logic signed [ELEMENT_WIDTH-1:0] m_00,
	input  logic signed [ELEMENT_WIDTH-1:0] m_01,
	input  logic signed [ELEMENT_WIDTH-1:0] m_02,
	input  logic signed [ELEMENT_WIDTH-1:0] m_10,
	input  logic signed [ELEMENT_WIDTH-1:0] m_11,
	input  logic signed [ELEMENT_WIDTH-1:0] m_12,
	input  logic signed [ELEMENT_WIDTH-1:0] m_20,
	input  logic signed [ELEMENT_WIDTH-1:0] m_21,
	input  logic signed [ELEMENT_WIDTH-1:0] m_22,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_ADDR_W-1:0]         paddr,
	input  logic [APB_DATA_W-1:0]         pwdata,
	output logic [APB_DATA_W-1:0]         prdata,
	output logic                          pready,
	// result transfer
	output logic                          done,
	output logic signed [ELEMENT_WIDTH-1:0] inv_00,
	output logic signed [ELEMENT_WIDTH-1:0] inv_01,
	output logic signed [ELEMENT_WIDTH-1:0] inv_02,
	output logic signed [ELEMENT_WIDTH-1:0] inv_10,
	output logic signed [ELEMENT_WIDTH-1:0] inv_11,
	output logic signed [ELEMENT_WIDTH-1:0] inv_12,
	output logic signed [ELEMENT_WIDTH-1:0] inv_20,
	output logic signed [ELEMENT_WIDTH-1:0] inv_21,
	output logic signed [ELEMENT_WIDTH-1:0] inv_22,
	output logic                          status,
	output logic                          saturated
);

	localparam int W        = ELEMENT_WIDTH;
	localparam int CW       = 2 * W + 1;
	localparam int DW       = 4 * W + 3;
	localparam int LANE_LAT = W + 2;

	logic [CFG_W-1:0] det_min_q;
	logic [CFG_W-1:0] det_max_q;
	logic             cfg_wr;

	logic signed [W-1:0] m   [NUM_ELEM];
	logic signed [W-1:0] inv [NUM_ELEM];
	logic [CW-1:0]       cof_mag [NUM_ELEM];
	logic                cof_neg [NUM_ELEM];
	logic [DW-1:0]       dmag;
	logic                dneg;
	logic [W:0]          q_lane   [NUM_ELEM];
	logic                neg_lane [NUM_ELEM];
	mi3_ctl_t            adj_ctl;
	mi3_ctl_t            ctl_d [LANE_LAT];

	// fully pipelined, so an item can be taken every cycle
	assign busy   = 1'b0;
	assign pready = 1'b1;

	assign m[0] = m_00;
	assign m[1] = m_01;
	assign m[2] = m_02;
	assign m[3] = m_10;
	assign m[4] = m_11;
	assign m[5] = m_12;
	assign m[6] = m_20;
	assign m[7] = m_21;
	assign m[8] = m_22;

	// bound registers, written in the access phase of a write transfer
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_min_q <= DET_MIN_RST;
			det_max_q <= DET_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_DET_MIN: det_min_q <= pwdata[CFG_W-1:0];
				REG_DET_MAX: det_max_q <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_DET_MIN: prdata = APB_DATA_W'(det_min_q);
			REG_DET_MAX: prdata = APB_DATA_W'(det_max_q);
		endcase
	end

	// cofactors, determinant and bound check
	mi3_adj #(
		.W(W)
	) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start && !busy),
		.m       (m),
		.det_min (det_min_q),
		.det_max (det_max_q),
		.cof_mag (cof_mag),
		.cof_neg (cof_neg),
		.dmag    (dmag),
		.dneg    (dneg),
		.ctl     (adj_ctl)
	);

	// one divider per inverse element
	for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
		mi3_div_lane #(
			.W(W),
			.F(FRACTION_BITS)
		) u_lane (
			.clk (clk),
			.cmag(cof_mag[k]),
			.cneg(cof_neg[k]),
			.dmag(dmag),
			.dneg(dneg),
			.q   (q_lane[k]),
			.neg (neg_lane[k])
		);
	end

	// valid and reject ride alongside the divider lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				ctl_d[i] <= '0;
			end
		end else begin
			ctl_d[0] <= adj_ctl;
			for (int i = 1; i < LANE_LAT; i++) begin
				ctl_d[i] <= ctl_d[i-1];
			end
		end
	end

	mi3_merge #(
		.W(W)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.q        (q_lane),
		.neg      (neg_lane),
		.ctl      (ctl_d[LANE_LAT-1]),
		.done     (done),
		.inv      (inv),
		.status   (status),
		.saturated(saturated)
	);

	assign inv_00 = inv[0];
	assign inv_01 = inv[1];
	assign inv_02 = inv[2];
	assign inv_10 = inv[3];
	assign inv_11 = inv[4];
	assign inv_12 = inv[5];
	assign inv_20 = inv[6];
	assign inv_21 = inv[7];
	assign inv_22 = inv[8];

	// a rejected determinant never reports clipping
	a_rej_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !saturated)
		else $error("saturated raised with rejected determinant");

	// a rejected determinant gives an all-zero inverse; checked on the diagonal and inv_12
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> inv_00 == '0 && inv_11 == '0 && inv_22 == '0 && inv_12 == '0)
		else $error("nonzero inverse with rejected determinant");

	// lower bound register follows the write transfer
	a_cfg_min: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && paddr[3] == REG_DET_MIN |=> det_min_q == $past(pwdata[CFG_W-1:0]))
		else $error("det_min write lost");

endmodule

### tb/mi3_checker.sv
`timescale 1ns / 1ps
// result checker for the 3x3 matrix inverse core: tracks the bound registers,
// predicts each inverse and compares it with the done strobe
// depends on mi3_pkg
module mi3_checker import mi3_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic signed [15:0]      m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [APB_ADDR_W-1:0]   paddr,
	input  logic [APB_DATA_W-1:0]   pwdata,
	input  logic                    done,
	input  logic signed [15:0]      inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
	input  logic signed [15:0]      inv_20, inv_21, inv_22,
	input  logic                    status,
	input  logic                    saturated,
	output int                      mismatches,
	output int                      pending,
	output int                      n_checked,
	output int                      n_rejected,
	output int                      n_clipped
);

	typedef struct {
		logic [15:0] elem [9];
		logic        reject;
		logic        clip;
	} inverse_t;

	logic [CFG_W-1:0] det_lo;
	logic [CFG_W-1:0] det_hi;
	inverse_t         inverse_q [$];

	assign pending = inverse_q.size();

	function automatic inverse_t predict_inverse(input logic signed [15:0] e [9]);
		inverse_t           res;
		longint             a [3][3];
		longint             adj [3][3];
		longint             det;
		longint unsigned    dmag, cm, n, q, lim;
		bit                 dneg, neg;
		for (int i = 0; i < 9; i++) begin
			a[i/3][i%3] = e[i];
		end
		adj[0][0] =   a[1][1]*a[2][2] - a[2][1]*a[1][2];
		adj[0][1] = -(a[0][1]*a[2][2] - a[2][1]*a[0][2]);
		adj[0][2] =   a[0][1]*a[1][2] - a[1][1]*a[0][2];
		adj[1][0] = -(a[1][0]*a[2][2] - a[2][0]*a[1][2]);
		adj[1][1] =   a[0][0]*a[2][2] - a[2][0]*a[0][2];
		adj[1][2] = -(a[0][0]*a[1][2] - a[1][0]*a[0][2]);
		adj[2][0] =   a[1][0]*a[2][1] - a[2][0]*a[1][1];
		adj[2][1] = -(a[0][0]*a[2][1] - a[2][0]*a[0][1]);
		adj[2][2] =   a[0][0]*a[1][1] - a[1][0]*a[0][1];
		det  = a[0][0]*adj[0][0] + a[0][1]*adj[1][0] + a[0][2]*adj[2][0];
		dneg = det < 0;
		dmag = dneg ? -det : det;
		res.clip = 1'b0;
		// rejected determinant: all-zero inverse, status up, no clip
		if (dmag == 0 || dmag < longint'(det_lo) || dmag > longint'(det_hi)) begin
			foreach (res.elem[i]) res.elem[i] = '0;
			res.reject = 1'b1;
			return res;
		end
		res.reject = 1'b0;
		for (int i = 0; i < 9; i++) begin
			cm  = adj[i/3][i%3] < 0 ? -adj[i/3][i%3] : adj[i/3][i%3];
			neg = (adj[i/3][i%3] < 0) != dneg;
			n   = cm << (2 * FRAC_DEF);
			q   = (n + (dmag >> 1)) / dmag;
			lim = neg ? 64'd32768 : 64'd32767;
			if (q > lim) begin
				q = lim;
				res.clip = 1'b1;
			end
			if (neg) q = -q;
			res.elem[i] = q[15:0];
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] mat [9];
		logic        [15:0] got [9];
		inverse_t           want;
		if (!arst_n) begin
			det_lo = DET_MIN_RST;
			det_hi = DET_MAX_RST;
			inverse_q.delete();
			mismatches = 0;
			n_checked  = 0;
			n_rejected = 0;
			n_clipped  = 0;
		end else begin
			// result first, so a matrix accepted at this edge cannot pair with it
			if (done) begin
				got = '{inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22};
				if (inverse_q.size() == 0) begin
					report("unexpected result", {15'd0, status}, 16'd0);
				end else begin
					want = inverse_q.pop_front();
					n_checked++;
					if (want.reject) n_rejected++;
					if (want.clip) n_clipped++;
					for (int i = 0; i < 9; i++)
						if (got[i] !== want.elem[i])
							report($sformatf("inv_%0d%0d", i/3, i%3), got[i], want.elem[i]);
					if (status !== want.reject)
						report("status", {15'd0, status}, {15'd0, want.reject});
					if (saturated !== want.clip)
						report("saturated", {15'd0, saturated}, {15'd0, want.clip});
				end
			end
			if (start && !busy) begin
				mat = '{m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22};
				inverse_q.push_back(predict_inverse(mat));
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_DET_MAX) det_hi = pwdata[CFG_W-1:0];
				else det_lo = pwdata[CFG_W-1:0];
			end
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// top of the 3x3 matrix inverse testbench: clock, reset, matrix and bound
// register stimulus, verdict; checking lives in mi3_checker (needs mi3_pkg)
module tb_top;
	import mi3_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PIPE_DRAIN     = 40;   // longer than the core pipeline

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic signed [15:0]    elem [9];
	logic                  psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;
	logic                  done, status, saturated;
	logic signed [15:0]    inv [9];
	int                    mismatches, pending, n_checked, n_rejected, n_clipped;
	int                    idle_cycles;
	int                    n_sent;
	bit                    quiet;          // long stretch with no sender gaps

	matrix3x3_inverse_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m_00(elem[0]), .m_01(elem[1]), .m_02(elem[2]),
		.m_10(elem[3]), .m_11(elem[4]), .m_12(elem[5]),
		.m_20(elem[6]), .m_21(elem[7]), .m_22(elem[8]),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.done(done),
		.inv_00(inv[0]), .inv_01(inv[1]), .inv_02(inv[2]),
		.inv_10(inv[3]), .inv_11(inv[4]), .inv_12(inv[5]),
		.inv_20(inv[6]), .inv_21(inv[7]), .inv_22(inv[8]),
		.status(status), .saturated(saturated)
	);

	mi3_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m_00(elem[0]), .m_01(elem[1]), .m_02(elem[2]),
		.m_10(elem[3]), .m_11(elem[4]), .m_12(elem[5]),
		.m_20(elem[6]), .m_21(elem[7]), .m_22(elem[8]),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.done(done),
		.inv_00(inv[0]), .inv_01(inv[1]), .inv_02(inv[2]),
		.inv_10(inv[3]), .inv_11(inv[4]), .inv_12(inv[5]),
		.inv_20(inv[6]), .inv_21(inv[7]), .inv_22(inv[8]),
		.status(status), .saturated(saturated),
		.mismatches(mismatches), .pending(pending), .n_checked(n_checked),
		.n_rejected(n_rejected), .n_clipped(n_clipped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: any transfer or register access restarts the count
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one matrix transfer; an optional random gap of idle cycles goes first
	task automatic send_matrix(input logic signed [15:0] v [9]);
		if (!quiet && $urandom_range(0, 99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		for (int i = 0; i < 9; i++) elem[i] <= v[i];
		// busy is sampled as the block saw it at this edge
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	// hold the sender until every pending inverse has come back
	task automatic drain;
		int guard;
		start <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < 10 * PIPE_DRAIN) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// bound register write, setup then access; pready is tied high in the block
	task automatic write_bound(input logic sel, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_bounds(input logic [APB_DATA_W-1:0] lo, input logic [APB_DATA_W-1:0] hi);
		drain();
		write_bound(REG_DET_MIN, lo);
		write_bound(REG_DET_MAX, hi);
		@(posedge clk);
	endtask

	// random matrix; nearly half are near a scaled identity so the divide path sees real inverses
	task automatic random_matrix(output logic signed [15:0] v [9]);
		int pick;
		pick = $urandom_range(0, 99);
		for (int i = 0; i < 9; i++) begin
			if (pick < 45) begin
				// near a scaled identity: diagonal +-0.25..3, small off-diagonal
				if (i % 4 == 0) v[i] = $urandom_range(0, 1) ? 16'($urandom_range(64, 768))
					: 16'(-$urandom_range(64, 768));
				else v[i] = 16'($urandom_range(0, 160) - 80);
			end else if (pick < 70) begin
				v[i] = 16'($urandom_range(0, 1023) - 512);
			end else begin
				v[i] = 16'($urandom);   // full 16-bit patterns
			end
		end
		// some singular ones: copy a row onto another
		if ($urandom_range(0, 99) < 6)
			for (int c = 0; c < 3; c++) v[6 + c] = v[c];
	endtask

	task automatic diag_matrix(input logic signed [15:0] d, input logic signed [15:0] off,
			output logic signed [15:0] v [9]);
		for (int i = 0; i < 9; i++) v[i] = (i % 4 == 0) ? d : off;
	endtask

	task automatic random_phase(input int count);
		logic signed [15:0] v [9];
		for (int k = 0; k < count; k++) begin
			random_matrix(v);
			send_matrix(v);
		end
	endtask

	initial begin
		logic signed [15:0] v [9];
		logic [APB_DATA_W-1:0] lo, hi;
		arst_n  = 1'b0;
		start   = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		for (int i = 0; i < 9; i++) elem[i] = '0;
		idle_cycles = 0;
		n_sent = 0;
		quiet  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed matrices under the reset bounds
		diag_matrix(16'sd256, 16'sd0, v);       send_matrix(v);   // identity
		diag_matrix(16'sd0, 16'sd0, v);         send_matrix(v);   // zero determinant
		diag_matrix(16'sd32767, 16'sd32767, v); send_matrix(v);   // all max, singular
		diag_matrix(-16'sd32768, -16'sd32768, v); send_matrix(v); // all min, singular
		diag_matrix(-16'sd32768, 16'sd0, v);    send_matrix(v);   // largest diagonal det magnitude
		diag_matrix(16'sd32767, 16'sd0, v);     send_matrix(v);
		diag_matrix(16'sd1, 16'sd0, v);         send_matrix(v);   // det of one lsb, clips
		diag_matrix(16'sd16, 16'sd0, v);        send_matrix(v);   // inverse of one sixteenth
		diag_matrix(16'sd128, 16'sd0, v);       send_matrix(v);   // inverse of one half
		diag_matrix(-16'sd256, 16'sd0, v);      send_matrix(v);   // negative determinant
		diag_matrix(16'sd768, 16'sd0, v);       send_matrix(v);   // inverse rounds
		v = '{16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd0};
		send_matrix(v);                                             // permutation
		v = '{16'sd256, 16'sd512, 16'sd768, 16'sd256, 16'sd512, 16'sd768,
			16'sd100, 16'sd9, 16'sd3};
		send_matrix(v);                                             // equal rows
		v = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
			16'sh7FFF, 16'sh8000, 16'sh0001};
		send_matrix(v);
		v = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
			-16'sd32768, 16'sd0, 16'sd32767};
		send_matrix(v);                                             // mixed extremes
		v = '{16'sd256, 16'sd255, 16'sd0, 16'sd255, 16'sd256, 16'sd0,
			16'sd0, 16'sd0, 16'sd256};
		send_matrix(v);                                             // near singular, clips

		// reset bounds, random; a long stretch in the middle has no sender gaps
		random_phase(150);
		quiet = 1'b1;
		random_phase(200);
		quiet = 1'b0;

		// both bounds at zero: every matrix rejected
		set_bounds(64'd0, 64'd0);
		diag_matrix(16'sd256, 16'sd0, v); send_matrix(v);
		random_phase(40);

		// narrow window around the identity determinant
		set_bounds(64'd1 << 23, 64'd1 << 25);
		diag_matrix(16'sd256, 16'sd0, v); send_matrix(v);
		diag_matrix(16'sd512, 16'sd0, v); send_matrix(v);
		random_phase(200);

		// crossed bounds reject everything
		set_bounds(64'd1 << 25, 64'd1 << 23);
		random_phase(40);

		// widest legal window, then upper bits above the register width
		set_bounds(64'd0, APB_DATA_W'(DET_MAX_RST));
		diag_matrix(16'sd0, 16'sd0, v); send_matrix(v);
		random_phase(200);
		set_bounds({16'hFFFF, 48'd1 << 20}, {16'hA5A5, DET_MAX_RST >> 4});
		random_phase(150);

		// random bounds, then back to reset values
		lo = APB_DATA_W'($urandom_range(0, 1 << 30));
		hi = {$urandom, $urandom} & 64'h0000_0FFF_FFFF_FFFF;
		set_bounds(lo, hi);
		random_phase(150);
		set_bounds(APB_DATA_W'(DET_MIN_RST), APB_DATA_W'(DET_MAX_RST));
		random_phase(100);

		drain();
		repeat (PIPE_DRAIN) @(posedge clk);

		$display("sent %0d matrices over eight bound settings; %0d inverses checked",
			n_sent, n_checked);
		$display("%0d with rejected determinant, %0d with clipped elements, %0d left over",
			n_rejected, n_clipped, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
